/* sv/lbg_pkg.sv */
// Types, pattern codes and LED tables for the bar gauge pattern sequencer.
package lbg_pkg;

   typedef logic [3:0] pattern_type;
   typedef logic [6:0] step_type;
   typedef logic [4:0] leds_type;

   localparam pattern_type PAT_OFF      = 4'd0;
   localparam pattern_type PAT_LVL_LAST = 4'd5;
   localparam pattern_type PAT_CRITICAL = 4'd6;
   localparam pattern_type PAT_COMPLETE = 4'd7;
   localparam pattern_type PAT_CHG_LAST = 4'd12;
   localparam pattern_type PAT_SEARCH   = 4'd13;
   localparam pattern_type PAT_FLASH    = 4'd14;
   localparam pattern_type CHG_TO_LVL   = 4'd7;

   localparam step_type STEP_LAST = 7'd87;
   localparam step_type STEP_MOD  = 7'd22;

   localparam leds_type LED_DARK = 5'h00;
   localparam leds_type LED_R    = 5'h01;
   localparam leds_type LED_Y1   = 5'h02;
   localparam leds_type LED_Y2   = 5'h04;
   localparam leds_type LED_G1   = 5'h08;
   localparam leds_type LED_G2   = 5'h10;
   localparam leds_type LED_ALL  = 5'h1F;

   localparam logic ACT_TICK   = 1'b0;
   localparam logic ACT_SELECT = 1'b1;

   // charge level bar: 0 dark, 1 full (100) down to 5 (20)
   function automatic leds_type level_leds(input logic [2:0] idx);
      leds_type v;
      case (idx)
         3'd1:    v = 5'h1F;
         3'd2:    v = 5'h0F;
         3'd3:    v = 5'h07;
         3'd4:    v = 5'h03;
         3'd5:    v = 5'h01;
         default: v = LED_DARK;
      endcase
      return v;
   endfunction

   function automatic leds_type search_leds(input logic [2:0] idx);
      leds_type v;
      case (idx)
         3'd0:    v = LED_R;
         3'd1:    v = LED_Y1;
         3'd2:    v = LED_Y2;
         3'd3:    v = LED_G1;
         3'd4:    v = LED_G2;
         3'd5:    v = LED_G1;
         3'd6:    v = LED_Y2;
         default: v = LED_Y1;
      endcase
      return v;
   endfunction

   function automatic leds_type sweep_leds(input logic [2:0] idx);
      leds_type v;
      case (idx)
         3'd1:    v = LED_R;
         3'd2:    v = LED_Y1;
         3'd3:    v = LED_Y2;
         3'd4:    v = LED_G1;
         3'd5:    v = LED_G2;
         default: v = LED_DARK;
      endcase
      return v;
   endfunction

endpackage

/* sv/lbg_req_if.sv */
// Request channel: tick or pattern select.
interface lbg_req_if import lbg_pkg::*;;
   logic        valid;
   logic        ready;
   logic        action;
   pattern_type pattern_sel;

   modport source (output valid, action, pattern_sel, input ready);
   modport sink   (input valid, action, pattern_sel, output ready);
endinterface

/* sv/lbg_rsp_if.sv */
// Response channel: LED word and animation flag.
interface lbg_rsp_if import lbg_pkg::*;;
   logic     valid;
   logic     ready;
   leds_type led_bits;
   logic     animating;

   modport source (output valid, led_bits, animating, input ready);
   modport sink   (input valid, led_bits, animating, output ready);
endinterface

/* sv/lbg_led_decode.sv */
// LED word for one step of a pattern.
module lbg_led_decode import lbg_pkg::*; (
   input  pattern_type pattern,
   input  step_type    step,
   input  leds_type    prev_leds,
   output leds_type    leds
);

   step_type    step_m22;
   logic [3:0]  phase;
   pattern_type lvl_idx;

   always_comb begin
      if (step >= 7'(3 * STEP_MOD)) begin
         step_m22 = step - 7'(3 * STEP_MOD);
      end else if (step >= 7'(2 * STEP_MOD)) begin
         step_m22 = step - 7'(2 * STEP_MOD);
      end else if (step >= STEP_MOD) begin
         step_m22 = step - STEP_MOD;
      end else begin
         step_m22 = step;
      end
   end

   assign phase   = step_m22[4:1];
   assign lvl_idx = pattern - CHG_TO_LVL;

   always_comb begin
      leds = prev_leds;
      if (pattern <= PAT_LVL_LAST) begin
         leds = level_leds(pattern[2:0]);
      end else if (pattern == PAT_CRITICAL) begin
         leds = step[1] ? LED_DARK : LED_R;
      end else if (pattern == PAT_COMPLETE) begin
         leds = LED_ALL;
      end else if (pattern <= PAT_CHG_LAST) begin
         // sweep, then settle on the level; later phases hold
         if (phase <= 4'd5) begin
            leds = sweep_leds(phase[2:0]);
         end else if (phase == 4'd6) begin
            leds = level_leds(lvl_idx[2:0]);
         end
      end else if (pattern == PAT_SEARCH) begin
         leds = search_leds(step[2:0]);
      end else if (pattern == PAT_FLASH) begin
         leds = step[0] ? LED_ALL : LED_DARK;
      end
   end

endmodule

/* sv/led_bar_gauge_pattern_sequencer.sv */
// Bar gauge pattern sequencer: request register, pattern state and response register.
//
// Usage: each request on req_ch is either a timer tick (action 0) or a pattern
// select (action 1, pattern_sel 0..14). A select of a new pattern restarts the
// step counter and answers with the LEDs of step 0; a select of the current
// pattern is swallowed. A tick answers with the next step only while the
// pattern animates, otherwise it is swallowed. Responses on rsp_ch carry
// led_bits (bit 0 red .. bit 4 green2) and animating.
// Timing: a request is registered in the request register on acceptance,
// and its response is then registered in the response register, whose
// valid flag drives rsp_ch.valid.
// Throughput: one request per cycle while rsp_ch does not stall, set by the single state update stage.
// Reset (synchronous, active high): pattern off, step 0, LEDs dark,
// ticking stopped, both registers empty.
// Stall: while rsp_ch.ready is low and a response is held, the request
// register holds too and req_ch.ready drops once it is full.
module led_bar_gauge_pattern_sequencer import lbg_pkg::*; (
   input logic        clock,
   input logic        reset,
   lbg_req_if.sink    req_ch,
   lbg_rsp_if.source  rsp_ch
);

   logic        in_valid_ff, in_valid_in;
   logic        in_action_ff;
   pattern_type in_sel_ff;

   pattern_type cur_pattern_ff, cur_pattern_in;
   step_type    step_ff, step_in;
   leds_type    lit_ff, lit_in;
   logic        tick_en_ff, tick_en_in;

   logic        out_valid_ff, out_valid_in;
   leds_type    out_leds_ff;
   logic        out_anim_ff;

   logic        out_free, stage_go, show;
   pattern_type eff_pattern;
   step_type    eff_step;
   logic        eff_tick;
   leds_type    new_leds;

   assign out_free     = !out_valid_ff || rsp_ch.ready;
   assign stage_go     = in_valid_ff && out_free;
   assign req_ch.ready = !in_valid_ff || out_free;
   assign in_valid_in  = req_ch.valid || (in_valid_ff && !out_free);

   always_comb begin
      show        = 1'b0;
      eff_pattern = cur_pattern_ff;
      eff_step    = step_ff;
      eff_tick    = tick_en_ff;
      if (in_action_ff == ACT_SELECT) begin
         if (in_sel_ff != cur_pattern_ff) begin
            show        = 1'b1;
            eff_pattern = in_sel_ff;
            eff_step    = '0;
            eff_tick    = (in_sel_ff > PAT_LVL_LAST);
         end
      end else begin
         show = tick_en_ff;
      end
   end

   lbg_led_decode u_decode (
      .pattern   (eff_pattern),
      .step      (eff_step),
      .prev_leds (lit_ff),
      .leds      (new_leds)
   );

   always_comb begin
      cur_pattern_in = cur_pattern_ff;
      step_in        = step_ff;
      lit_in         = lit_ff;
      tick_en_in     = tick_en_ff;
      if (stage_go && show) begin
         cur_pattern_in = eff_pattern;
         tick_en_in     = eff_tick;
         lit_in         = new_leds;
         step_in        = (eff_step == STEP_LAST) ? '0 : eff_step + 7'd1;
      end
   end

   assign out_valid_in = (stage_go && show) || (out_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         cur_pattern_ff <= PAT_OFF;
         step_ff        <= '0;
         lit_ff         <= LED_DARK;
         tick_en_ff     <= 1'b0;
      end else begin
         in_valid_ff    <= in_valid_in;
         out_valid_ff   <= out_valid_in;
         cur_pattern_ff <= cur_pattern_in;
         step_ff        <= step_in;
         lit_ff         <= lit_in;
         tick_en_ff     <= tick_en_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_action_ff <= req_ch.action;
         in_sel_ff    <= req_ch.pattern_sel;
      end
      if (stage_go && show) begin
         out_leds_ff <= new_leds;
         out_anim_ff <= eff_tick;
      end
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.led_bits  = out_leds_ff;
   assign rsp_ch.animating = out_anim_ff;

endmodule
